// ===== rtl/gps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_pkg
// shared types and constants for the particle gravity step block
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int NumParticles = 4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [1:0] REG_SOURCE_X = 2'd0;
  localparam logic [1:0] REG_SOURCE_Y = 2'd1;
  localparam logic [1:0] REG_STRENGTH = 2'd2;
  localparam logic [1:0] REG_MIN_DIST = 2'd3;

  localparam logic [31:0] SOURCE_X_RST = 32'd41943040;
  localparam logic [31:0] SOURCE_Y_RST = 32'd23592960;
  localparam logic [31:0] STRENGTH_RST = 32'd1920000;
  localparam logic [30:0] MIN_DIST_RST = 31'd655360;

  // acceleration magnitude limit, 2^33
  localparam logic [33:0] ACC_LIMIT = 34'h2_0000_0000;

  // request to the iterative divider
  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [95:0]  den;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] quo;
  } div_rsp_t;

  // clamp a 36-bit signed sum to 32 bits, flag when clamped
  function automatic logic [32:0] sat32(input logic signed [35:0] v);
    logic [32:0] r;
    if (v > 36'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -36'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/gps_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_div
// restoring divider, one quotient bit per cycle, 128-bit numerator
// ----------------------------------------------------------------------------
module gps_div (
  input  logic              clk,
  input  logic              rst,
  input  gps_pkg::div_req_t req,
  output gps_pkg::div_rsp_t rsp
);
  import gps_pkg::*;

  logic         busy;
  logic         done;
  logic [6:0]   count;
  logic [127:0] quo;
  logic [96:0]  rem;
  logic [95:0]  den;
  logic [97:0]  trial;
  logic [96:0]  shifted;

  assign shifted = {rem[95:0], quo[127]};
  assign trial   = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
        quo   <= req.num;
        rem   <= '0;
        den   <= req.den;
      end else if (busy) begin
        if (!trial[97]) begin
          rem <= trial[96:0];
          quo <= {quo[126:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[126:0], 1'b0};
        end
        count <= count + 7'd1;
        if (count == 7'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo};

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) rsp.done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

  property p_start_busy;
    @(posedge clk) disable iff (rst) req.start |=> busy;
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("start did not set busy");

  property p_remainder_bound;
    @(posedge clk) disable iff (rst) busy |-> (rem < {1'b0, den});
  endproperty
  a_remainder_bound: assert property (p_remainder_bound) else $error("remainder out of range");

endmodule

// ===== rtl/gravity_particle_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_particle_step
// semi-implicit euler step of point particles round one fixed point mass
// ----------------------------------------------------------------------------
// load, or step of a particle never loaded: S_READ goes straight to S_OUT, which raises out_valid
// step too close: ends in S_CUBE1 after the square root; step at zero distance: S_CUBE1 goes to S_VEL
// full step: square root, the multiplies for d cubed (S_CUBE1 to S_CUBE3)
//   and two divisions through the shared divider
// in_stall stays high until the result is taken; the next accept can come in the cycle after
// rst clears control and loaded bits, sets configuration to reset values; particle store undefined
module gravity_particle_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [1:0]  particle,
  input  logic [31:0] load_pos_x,
  input  logic [31:0] load_pos_y,
  input  logic [31:0] load_vel_x,
  input  logic [31:0] load_vel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_particle,
  output logic [31:0] new_pos_x,
  output logic [31:0] new_pos_y,
  output logic [31:0] new_vel_x,
  output logic [31:0] new_vel_y,
  output logic        too_close,
  output logic        saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gps_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_OFF   = 4'd2;
  localparam logic [3:0] S_SQX   = 4'd3;
  localparam logic [3:0] S_SQY   = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_CUBE1 = 4'd6;
  localparam logic [3:0] S_CUBE2 = 4'd7;
  localparam logic [3:0] S_MULX  = 4'd8;
  localparam logic [3:0] S_DIVX  = 4'd9;
  localparam logic [3:0] S_MULY  = 4'd10;
  localparam logic [3:0] S_DIVY  = 4'd11;
  localparam logic [3:0] S_VEL   = 4'd12;
  localparam logic [3:0] S_POS   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;
  localparam logic [3:0] S_CUBE3 = 4'd15;

  logic [3:0] state;

  logic [31:0] source_x, source_y, strength;
  logic [30:0] min_dist;

  logic [31:0] mem_px [NumParticles];
  logic [31:0] mem_py [NumParticles];
  logic [31:0] mem_vx [NumParticles];
  logic [31:0] mem_vy [NumParticles];
  logic [NumParticles-1:0] loaded;

  logic        item_kind;
  logic [1:0]  idx;
  logic [31:0] px, py, vx, vy;
  logic        dx_neg, dy_neg;
  logic [31:0] ax, ay;
  logic [64:0] sumsq;
  logic [64:0] sq_rem;
  logic [31:0] root;
  logic [4:0]  sq_count;
  logic [95:0] cube;
  logic [33:0] acc_x, acc_y;
  logic        close, sat;
  logic        div_wait;

  div_req_t div_req;
  div_rsp_t div_rsp;

  gps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // shared multiplier, 32x32 into 64 bits, operands chosen by state
  // d cubed takes root squared, then root times each half of it
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = ax;
    mul_b = ax;
    unique case (state)
      S_SQX:   begin mul_a = ax;       mul_b = ax;           end
      S_SQY:   begin mul_a = ay;       mul_b = ay;           end
      S_CUBE1: begin mul_a = root;     mul_b = root;         end
      S_CUBE2: begin mul_a = root;     mul_b = cube[31:0];   end
      S_CUBE3: begin mul_a = root;     mul_b = cube[95:64];  end
      S_MULX:  begin mul_a = strength; mul_b = ax;           end
      S_MULY:  begin mul_a = strength; mul_b = ay;           end
      default: begin mul_a = ax;       mul_b = ax;           end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // offsets, saturated
  logic signed [35:0] off_x, off_y;
  logic [32:0] sx, sy;
  assign off_x = {{4{source_x[31]}}, source_x} - {{4{px[31]}}, px};
  assign off_y = {{4{source_y[31]}}, source_y} - {{4{py[31]}}, py};
  assign sx = sat32(off_x);
  assign sy = sat32(off_y);

  // square root, two bits of the radicand per cycle
  logic [5:0]  sq_sh;
  logic [1:0]  sq_pair;
  logic [66:0] sq_trial_rem;
  logic [66:0] sq_trial;
  assign sq_sh        = {sq_count, 1'b0};
  assign sq_pair      = sumsq[7'(sq_sh) + 7'd1 -: 2];
  assign sq_trial_rem = {sq_rem, sq_pair};
  assign sq_trial     = sq_trial_rem - {33'd0, root, 2'b01};

  // quotient limit to ACC_LIMIT; the sign is applied in the velocity sums
  logic [33:0] quo_lim;
  assign quo_lim = (div_rsp.quo[127:33] != '0) ? ACC_LIMIT : div_rsp.quo[33:0];

  // acceleration reaches 2^33, so the velocity sum needs 36 bits
  logic signed [35:0] vsum_x, vsum_y, psum_x, psum_y;
  logic [32:0] nvx, nvy, npx, npy;
  assign vsum_x = {{4{vx[31]}}, vx} +
                  (dx_neg ? (36'd0 - {2'b00, acc_x}) : {2'b00, acc_x});
  assign vsum_y = {{4{vy[31]}}, vy} +
                  (dy_neg ? (36'd0 - {2'b00, acc_y}) : {2'b00, acc_y});
  assign nvx = sat32(vsum_x);
  assign nvy = sat32(vsum_y);
  assign psum_x = {{4{px[31]}}, px} + {{4{vx[31]}}, vx};
  assign psum_y = {{4{py[31]}}, py} + {{4{vy[31]}}, vy};
  assign npx = sat32(psum_x);
  assign npy = sat32(psum_y);

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_x <= SOURCE_X_RST;
      source_y <= SOURCE_Y_RST;
      strength <= STRENGTH_RST;
      min_dist <= MIN_DIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_X: source_x <= cfg_data;
        REG_SOURCE_Y: source_y <= cfg_data;
        REG_STRENGTH: strength <= cfg_data;
        REG_MIN_DIST: min_dist <= cfg_data[30:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      loaded        <= '0;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
      div_wait      <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_kind <= kind;
            idx       <= particle;
            px <= load_pos_x; py <= load_pos_y;
            vx <= load_vel_x; vy <= load_vel_y;
            close <= 1'b0;
            sat   <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (item_kind == KIND_LOAD) begin
            mem_px[idx] <= px; mem_py[idx] <= py;
            mem_vx[idx] <= vx; mem_vy[idx] <= vy;
            loaded[idx] <= 1'b1;
            state <= S_OUT;
          end else if (!loaded[idx]) begin
            px <= '0; py <= '0; vx <= '0; vy <= '0;
            state <= S_OUT;
          end else begin
            px <= mem_px[idx]; py <= mem_py[idx];
            vx <= mem_vx[idx]; vy <= mem_vy[idx];
            state <= S_OFF;
          end
        end
        S_OFF: begin
          dx_neg <= sx[31];
          dy_neg <= sy[31];
          ax <= sx[31] ? (32'd0 - sx[31:0]) : sx[31:0];
          ay <= sy[31] ? (32'd0 - sy[31:0]) : sy[31:0];
          state <= S_SQX;
        end
        S_SQX: begin
          sumsq <= {1'b0, mul_p};
          state <= S_SQY;
        end
        S_SQY: begin
          sumsq    <= sumsq + {1'b0, mul_p};
          sq_rem   <= '0;
          root     <= '0;
          sq_count <= 5'd31;
          state    <= S_SQRT;
        end
        S_SQRT: begin
          // radicand at most 2^63, so the root fits 32 bits
          if (!sq_trial[66]) begin
            sq_rem <= sq_trial[64:0];
            root   <= {root[30:0], 1'b1};
          end else begin
            sq_rem <= sq_trial_rem[64:0];
            root   <= {root[30:0], 1'b0};
          end
          sq_count <= sq_count - 5'd1;
          if (sq_count == 5'd0) begin
            state <= S_CUBE1;
          end
        end
        S_CUBE1: begin
          if ({1'b0, root} < {1'b0, min_dist}) begin
            close <= 1'b1;
            state <= S_OUT;
          end else if (root == '0) begin
            acc_x <= '0;
            acc_y <= '0;
            state <= S_VEL;
          end else begin
            cube  <= {32'd0, mul_p};
            state <= S_CUBE2;
          end
        end
        S_CUBE2: begin
          // keep the upper half of the square beside the low partial product
          cube  <= {cube[63:32], mul_p};
          state <= S_CUBE3;
        end
        S_CUBE3: begin
          cube  <= {mul_p, 32'd0} + {32'd0, cube[63:0]};
          state <= S_MULX;
        end
        S_MULX: begin
          div_req.start <= 1'b1;
          div_req.num   <= {24'd0, mul_p, 40'd0};
          div_req.den   <= cube;
          div_wait      <= 1'b1;
          state         <= S_DIVX;
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            acc_x <= quo_lim;
            state <= S_MULY;
          end
        end
        S_MULY: begin
          div_req.start <= 1'b1;
          div_req.num   <= {24'd0, mul_p, 40'd0};
          div_req.den   <= cube;
          state         <= S_DIVY;
        end
        S_DIVY: begin
          if (div_rsp.done) begin
            acc_y    <= quo_lim;
            div_wait <= 1'b0;
            state    <= S_VEL;
          end
        end
        S_VEL: begin
          vx  <= nvx[31:0];
          vy  <= nvy[31:0];
          sat <= sat | nvx[32] | nvy[32];
          state <= S_POS;
        end
        S_POS: begin
          px  <= npx[31:0];
          py  <= npy[31:0];
          sat <= sat | npx[32] | npy[32];
          mem_px[idx] <= npx[31:0]; mem_py[idx] <= npy[31:0];
          mem_vx[idx] <= vx;        mem_vy[idx] <= vy;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_particle = idx;
  assign new_pos_x    = px;
  assign new_pos_y    = py;
  assign new_vel_x    = vx;
  assign new_vel_y    = vy;
  assign too_close    = close;
  assign saturated    = sat;

  property p_out_only_in_out;
    @(posedge clk) disable iff (rst) out_valid |-> (state == S_OUT);
  endproperty
  a_out_only_in_out: assert property (p_out_only_in_out) else $error("result outside output state");

  property p_close_no_sat;
    @(posedge clk) disable iff (rst) (out_valid && too_close) |-> !saturated;
  endproperty
  a_close_no_sat: assert property (p_close_no_sat) else $error("too close with saturation");

  property p_div_in_step;
    @(posedge clk) disable iff (rst) div_req.start |-> (item_kind == KIND_STEP) && div_wait;
  endproperty
  a_div_in_step: assert property (p_div_in_step) else $error("divider started outside a step");

  property p_load_marks;
    @(posedge clk) disable iff (rst)
      (state == S_READ && item_kind == KIND_LOAD) |=> loaded[$past(idx)];
  endproperty
  a_load_marks: assert property (p_load_marks) else $error("load did not mark particle");

endmodule

// ===== dv/tb_gravity_particle_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gravity_particle_step
// checks particle load and gravity step results against a cycle-free model
// of the particle store, with random idling on both channels, configuration
// changes between phases and one long output hold-off
// ----------------------------------------------------------------------------
module tb_gravity_particle_step;
  import gps_pkg::*;

  typedef struct {
    logic [1:0]  particle;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic        close;
    logic        sat;
  } particle_state_t;

  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam logic [127:0] AccCap = 128'h2_0000_0000;
  localparam logic [31:0] Unit = 32'h0001_0000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [1:0]  particle;
  logic [31:0] load_pos_x;
  logic [31:0] load_pos_y;
  logic [31:0] load_vel_x;
  logic [31:0] load_vel_y;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_particle;
  logic [31:0] new_pos_x;
  logic [31:0] new_pos_y;
  logic [31:0] new_vel_x;
  logic [31:0] new_vel_y;
  logic        too_close;
  logic        saturated;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // model copy of configuration and particle store
  logic signed [31:0] src_x_cfg;
  logic signed [31:0] src_y_cfg;
  logic [31:0]        strength_cfg;
  logic [30:0]        min_dist_cfg;
  logic signed [31:0] pos_x_mdl [NumParticles];
  logic signed [31:0] pos_y_mdl [NumParticles];
  logic signed [31:0] vel_x_mdl [NumParticles];
  logic signed [31:0] vel_y_mdl [NumParticles];
  bit                 loaded_mdl [NumParticles];

  particle_state_t expected_states[$];
  int  n_errors;
  bit  quiet;
  bit  long_hold_req;
  int  hold_cnt;

  gravity_particle_step i_dut (.*);

  always #1 clk = ~clk;

  function automatic longint clamp_s32(input longint v, inout bit sat);
    if (v > S32Max) begin
      sat = 1;
      return S32Max;
    end
    if (v < S32Min) begin
      sat = 1;
      return S32Min;
    end
    return v;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint gravity_accel(input longint off, input logic [63:0] d);
    logic [127:0] mag;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    if (d == 0) return 0;
    mag = off < 0 ? 128'(-off) : 128'(off);
    num = (mag * 128'(strength_cfg)) << 40;
    den = 128'(d) * 128'(d) * 128'(d);
    q = num / den;
    if (q > AccCap) q = AccCap;
    return off < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic particle_state_t advance_particle(input logic k, input logic [1:0] p,
      input logic [31:0] lpx, input logic [31:0] lpy, input logic [31:0] lvx,
      input logic [31:0] lvy);
    particle_state_t r;
    longint px, py, vx, vy, dx, dy;
    logic [63:0] ax, ay, d;
    bit sat, dummy;
    r = '{particle: p, default: '0};
    sat = 0;
    dummy = 0;
    if (k == KIND_LOAD) begin
      pos_x_mdl[p] = lpx;
      pos_y_mdl[p] = lpy;
      vel_x_mdl[p] = lvx;
      vel_y_mdl[p] = lvy;
      loaded_mdl[p] = 1;
      r.pos_x = lpx;
      r.pos_y = lpy;
      r.vel_x = lvx;
      r.vel_y = lvy;
    end else if (loaded_mdl[p]) begin
      px = longint'(pos_x_mdl[p]);
      py = longint'(pos_y_mdl[p]);
      vx = longint'(vel_x_mdl[p]);
      vy = longint'(vel_y_mdl[p]);
      dx = clamp_s32(longint'(src_x_cfg) - px, dummy);
      dy = clamp_s32(longint'(src_y_cfg) - py, dummy);
      ax = dx < 0 ? 64'(-dx) : 64'(dx);
      ay = dy < 0 ? 64'(-dy) : 64'(dy);
      d = floor_sqrt(ax * ax + ay * ay);
      if (d < 64'(min_dist_cfg)) begin
        r.close = 1;
      end else begin
        vx = clamp_s32(vx + gravity_accel(dx, d), sat);
        vy = clamp_s32(vy + gravity_accel(dy, d), sat);
        px = clamp_s32(px + vx, sat);
        py = clamp_s32(py + vy, sat);
        pos_x_mdl[p] = px[31:0];
        pos_y_mdl[p] = py[31:0];
        vel_x_mdl[p] = vx[31:0];
        vel_y_mdl[p] = vy[31:0];
      end
      r.pos_x = px[31:0];
      r.pos_y = py[31:0];
      r.vel_x = vx[31:0];
      r.vel_y = vy[31:0];
      r.sat = sat;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int sel;
    if (quiet) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_item(input logic k, input logic [1:0] p, input logic [31:0] lpx,
      input logic [31:0] lpy, input logic [31:0] lvx, input logic [31:0] lvy);
    int gap;
    in_valid <= 1'b1;
    kind <= k;
    particle <= p;
    load_pos_x <= lpx;
    load_pos_y <= lpy;
    load_vel_x <= lvx;
    load_vel_y <= lvy;
    do @(posedge clk); while (in_stall);
    expected_states.insert(expected_states.size(),
                           advance_particle(k, p, lpx, lpy, lvx, lvy));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOURCE_X: src_x_cfg = data;
      REG_SOURCE_Y: src_y_cfg = data;
      REG_STRENGTH: strength_cfg = data;
      default: min_dist_cfg = data[30:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] sx, input logic [31:0] sy,
      input logic [31:0] s, input logic [31:0] md);
    wait_idle();
    write_reg(REG_SOURCE_X, sx);
    write_reg(REG_SOURCE_Y, sy);
    write_reg(REG_STRENGTH, s);
    write_reg(REG_MIN_DIST, md);
  endtask

  task automatic step_item(input logic [1:0] p);
    send_item(KIND_STEP, p, $urandom, $urandom, $urandom, $urandom);
  endtask

  // default source, edge values and the basic special cases
  task automatic test_directed();
    step_item(2'd0);
    send_item(KIND_LOAD, 2'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_item(KIND_LOAD, 2'd2, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    step_item(2'd1);
    step_item(2'd2);
    send_item(KIND_LOAD, 2'd3, SOURCE_X_RST + 5 * Unit, SOURCE_Y_RST, 32'h0, Unit);
    step_item(2'd3);
    send_item(KIND_LOAD, 2'd0, SOURCE_X_RST + 100 * Unit, SOURCE_Y_RST, 32'h0, 2 * Unit);
    repeat (3) step_item(2'd0);
  endtask

  // zero distance, strength and source extremes, everything too close
  task automatic test_config_extremes();
    set_config(SOURCE_X_RST, SOURCE_Y_RST, STRENGTH_RST, 32'h0);
    send_item(KIND_LOAD, 2'd0, SOURCE_X_RST, SOURCE_Y_RST, Unit, -Unit);
    repeat (2) step_item(2'd0);
    set_config(SOURCE_X_RST, SOURCE_Y_RST, 32'hffff_ffff, 32'h0);
    send_item(KIND_LOAD, 2'd1, SOURCE_X_RST + 3 * Unit, SOURCE_Y_RST - 7, 32'h0, 32'h0);
    step_item(2'd1);
    set_config(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
    send_item(KIND_LOAD, 2'd2, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 32'h8765_4321);
    step_item(2'd2);
    set_config(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
    step_item(2'd2);
    step_item(2'd1);
  endtask

  // hold the output off long enough that the input backs up
  task automatic test_backpressure();
    set_config(SOURCE_X_RST, SOURCE_Y_RST, STRENGTH_RST, {1'b0, MIN_DIST_RST});
    quiet = 1;
    long_hold_req = 1;
    send_item(KIND_LOAD, 2'd3, SOURCE_X_RST - 50 * Unit, SOURCE_Y_RST + 20 * Unit, 32'h0, Unit);
    repeat (5) step_item(2'd3);
    quiet = 0;
  endtask

  task automatic random_orbits(input int n_items);
    int sent;
    int sel;
    logic [1:0] p;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      p = $urandom_range(0, NumParticles - 1);
      if (sel < 80) begin
        send_item(KIND_LOAD, p,
                  src_x_cfg + $signed($urandom_range(0, 800 << 16)) - (400 << 16),
                  src_y_cfg + $signed($urandom_range(0, 800 << 16)) - (400 << 16),
                  $signed($urandom_range(0, 16 << 16)) - (8 << 16),
                  $signed($urandom_range(0, 16 << 16)) - (8 << 16));
        sent++;
        repeat ($urandom_range(1, 8)) begin
          step_item(p);
          sent++;
        end
      end else if (sel < 90) begin
        send_item(KIND_LOAD, p, $urandom, $urandom, $urandom, $urandom);
        sent++;
      end else begin
        send_item($urandom_range(0, 1), p, $urandom, $urandom, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  task automatic test_random();
    set_config(SOURCE_X_RST, SOURCE_Y_RST, STRENGTH_RST, {1'b0, MIN_DIST_RST});
    random_orbits(190);
    set_config($signed($urandom_range(0, 2000 << 16)) - (1000 << 16),
               $signed($urandom_range(0, 2000 << 16)) - (1000 << 16),
               $urandom_range(0, 32'h0100_0000), $urandom_range(0, 40 << 16));
    random_orbits(190);
    set_config($urandom, $urandom, $urandom, $urandom_range(0, 200 << 16));
    random_orbits(190);
  endtask

  // output stall: short random stalls, quiet stretches, one long hold
  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_cnt = 2000;
      long_hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (quiet || rst) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 299) == 0) begin
      hold_cnt = $urandom_range(10, 60);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    particle_state_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_states.size() == 0) begin
        $error("result transaction with no expectation, particle %0d", out_particle);
        n_errors++;
      end else begin
        e = expected_states.pop_front();
        if (out_particle !== e.particle) begin
          $error("out_particle exp %0d got %0d", e.particle, out_particle);
          n_errors++;
        end
        if (new_pos_x !== e.pos_x) begin
          $error("new_pos_x exp %h got %h", e.pos_x, new_pos_x);
          n_errors++;
        end
        if (new_pos_y !== e.pos_y) begin
          $error("new_pos_y exp %h got %h", e.pos_y, new_pos_y);
          n_errors++;
        end
        if (new_vel_x !== e.vel_x) begin
          $error("new_vel_x exp %h got %h", e.vel_x, new_vel_x);
          n_errors++;
        end
        if (new_vel_y !== e.vel_y) begin
          $error("new_vel_y exp %h got %h", e.vel_y, new_vel_y);
          n_errors++;
        end
        if (too_close !== e.close) begin
          $error("too_close exp %0b got %0b", e.close, too_close);
          n_errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated exp %0b got %0b", e.sat, saturated);
          n_errors++;
        end
      end
    end
  end

  initial begin
    clk = 0;
    rst = 1;
    in_valid = 0;
    kind = KIND_LOAD;
    particle = '0;
    load_pos_x = '0;
    load_pos_y = '0;
    load_vel_x = '0;
    load_vel_y = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = REG_SOURCE_X;
    cfg_data = '0;
    n_errors = 0;
    quiet = 0;
    long_hold_req = 0;
    hold_cnt = 0;
    src_x_cfg = SOURCE_X_RST;
    src_y_cfg = SOURCE_Y_RST;
    strength_cfg = STRENGTH_RST;
    min_dist_cfg = MIN_DIST_RST;
    foreach (loaded_mdl[i]) loaded_mdl[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
